FILE: src/tga_rle_pixel_decoder_core_assert.svh
// Assertion macros for the TGA run-length pixel decoder.
// Needs clk_i and rst_ni in the scope that uses them.
`ifndef TGA_RLE_PIXEL_DECODER_CORE_ASSERT_SVH
`define TGA_RLE_PIXEL_DECODER_CORE_ASSERT_SVH

// same-cycle implication
`define TGARLE_ASSERT_IMPLY(name, ante, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define TGARLE_ASSERT_NEXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: src/tgarle_pkg.sv
// Shared types and constants of the TGA run-length pixel decoder.
// No dependencies.
`default_nettype none

package tgarle_pkg;

  localparam int unsigned MAX_PIXEL_BYTES_DEF = 8;
  localparam int unsigned DIM_BITS_DEF        = 16;

  localparam int unsigned BYTE_W      = 8;
  localparam int unsigned IDX_W       = 32;
  localparam int unsigned PIX_OUT_W   = 64;
  localparam int unsigned CNT_W       = 8;
  localparam int unsigned CFG_IDX_W   = 2;
  localparam int unsigned CFG_DATA_W  = 16;
  localparam int unsigned CFG_DIM_W   = 16;
  localparam int unsigned PB_W        = 4;
  localparam int unsigned CORNER_W    = 2;
  localparam int unsigned QUEUE_DEPTH = 2;
  localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int unsigned QCNT_W      = $clog2(QUEUE_DEPTH + 1);
  localparam int unsigned TDATA_OUT_W = 2 * (IDX_W + PIX_OUT_W);
  localparam int unsigned TUSER_OUT_W = 2;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_WIDTH   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_HEIGHT  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_PIXEL_BYTES   = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_ORIGIN_CORNER = 2'd3;

  localparam logic [CFG_DIM_W-1:0] RST_IMAGE_WIDTH   = 16'd1;
  localparam logic [CFG_DIM_W-1:0] RST_IMAGE_HEIGHT  = 16'd1;
  localparam logic [PB_W-1:0]      RST_PIXEL_BYTES   = 4'd4;
  localparam logic [CORNER_W-1:0]  RST_ORIGIN_CORNER = 2'd2;

  localparam logic [CORNER_W-1:0] CORNER_BL = 2'd0;
  localparam logic [CORNER_W-1:0] CORNER_BR = 2'd1;
  localparam logic [CORNER_W-1:0] CORNER_TL = 2'd2;
  localparam logic [CORNER_W-1:0] CORNER_TR = 2'd3;

  typedef enum logic [2:0] {
    ST_HEADER,
    ST_LITERAL,
    ST_RUN,
    ST_EMIT,
    ST_ORIGIN
  } state_e;

  // classified input word
  typedef struct packed {
    logic              is_begin;
    logic              is_run;
    logic [CNT_W-1:0]  count;
    logic [BYTE_W-1:0] data;
  } item_t;

  typedef struct packed {
    logic [IDX_W-1:0]     first_index;
    logic [PIX_OUT_W-1:0] first_pixel;
    logic                 second_valid;
    logic [IDX_W-1:0]     second_index;
    logic [PIX_OUT_W-1:0] second_pixel;
    logic                 last_of_run;
    logic                 image_done;
  } res_t;

endpackage

`default_nettype wire

FILE: src/tgarle_front.sv
// Front end: accepts input words, classifies them and queues them.
// Depends on tgarle_pkg and the assertion header.
`default_nettype none

`include "tga_rle_pixel_decoder_core_assert.svh"

module tgarle_front (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              s_valid_i,
  output logic                                   s_ready_o,
  input  wire logic                              action_i,
  input  wire logic [tgarle_pkg::BYTE_W-1:0]     data_byte_i,
  output tgarle_pkg::item_t                      item_o,
  output logic                                   item_valid_o,
  input  wire logic                              item_pop_i
);

  tgarle_pkg::item_t                  entry_q [tgarle_pkg::QUEUE_DEPTH];
  tgarle_pkg::item_t                  class_item;
  logic [tgarle_pkg::QPTR_W-1:0]      wr_ptr_q, wr_ptr_d;
  logic [tgarle_pkg::QPTR_W-1:0]      rd_ptr_q, rd_ptr_d;
  logic [tgarle_pkg::QCNT_W-1:0]      count_q, count_d;
  logic                               push;

  // header count: literal is b+1, run is b-127; both equal low seven bits plus one
  always_comb begin
    class_item.is_begin = action_i;
    class_item.is_run   = data_byte_i[tgarle_pkg::BYTE_W-1];
    class_item.count    = tgarle_pkg::CNT_W'({1'b0, data_byte_i[tgarle_pkg::BYTE_W-2:0]})
                          + tgarle_pkg::CNT_W'(1);
    class_item.data     = data_byte_i;
  end

  assign s_ready_o    = (count_q != tgarle_pkg::QCNT_W'(tgarle_pkg::QUEUE_DEPTH));
  assign push         = s_valid_i && s_ready_o;
  assign item_valid_o = (count_q != '0);
  assign item_o       = entry_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = push ? wr_ptr_q + tgarle_pkg::QPTR_W'(1) : wr_ptr_q;
    rd_ptr_d = item_pop_i ? rd_ptr_q + tgarle_pkg::QPTR_W'(1) : rd_ptr_q;
    count_d  = count_q + tgarle_pkg::QCNT_W'(push) - tgarle_pkg::QCNT_W'(item_pop_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      entry_q[wr_ptr_q] <= class_item;
    end
  end

  `TGARLE_ASSERT_IMPLY(a_fill_bound, 1'b1, count_q <= tgarle_pkg::QCNT_W'(tgarle_pkg::QUEUE_DEPTH), "queue overfilled")
  `TGARLE_ASSERT_IMPLY(a_pop_nonempty, item_pop_i, count_q != '0, "pop from empty queue")

endmodule

`default_nettype wire

FILE: src/tgarle_back.sv
// Back end: packet sequencer, pixel assembly, position stepping, result register.
// Depends on tgarle_pkg and the assertion header.
`default_nettype none

`include "tga_rle_pixel_decoder_core_assert.svh"

module tgarle_back #(
  parameter int unsigned MAX_PIXEL_BYTES = tgarle_pkg::MAX_PIXEL_BYTES_DEF,
  parameter int unsigned DIM_BITS        = tgarle_pkg::DIM_BITS_DEF
) (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  input  wire tgarle_pkg::item_t                   item_i,
  input  wire logic                                item_valid_i,
  output logic                                     item_pop_o,
  input  wire logic [DIM_BITS-1:0]                 width_i,
  input  wire logic [DIM_BITS-1:0]                 height_i,
  input  wire logic [tgarle_pkg::PB_W-1:0]         pixel_bytes_i,
  input  wire logic [tgarle_pkg::CORNER_W-1:0]     corner_i,
  output logic                                     res_valid_o,
  input  wire logic                                res_ready_i,
  output tgarle_pkg::res_t                         res_o
);

  localparam int unsigned PIX_W  = MAX_PIXEL_BYTES * tgarle_pkg::BYTE_W;
  localparam int unsigned SLOT_W = (MAX_PIXEL_BYTES > 1) ? $clog2(MAX_PIXEL_BYTES) : 1;
  localparam int unsigned IDX_W  = tgarle_pkg::IDX_W;
  localparam int unsigned CNT_W  = tgarle_pkg::CNT_W;
  localparam int unsigned PB_W   = tgarle_pkg::PB_W;

  typedef struct packed {
    logic [IDX_W-1:0]    idx;
    logic [DIM_BITS-1:0] col;
    logic [DIM_BITS-1:0] rows;
    logic                fin;
  } pos_t;

  // one pixel write: step along the row; at its end reload (BL/TR jump) or finish
  function automatic pos_t step_pos(input pos_t p, input logic [DIM_BITS-1:0] w,
                                    input logic [tgarle_pkg::CORNER_W-1:0] c);
    pos_t             r;
    logic [IDX_W-1:0] w2;
    r  = p;
    w2 = IDX_W'(w) << 1;
    if (c == tgarle_pkg::CORNER_BL || c == tgarle_pkg::CORNER_TL) begin
      r.idx = p.idx + IDX_W'(1);
    end else begin
      r.idx = p.idx - IDX_W'(1);
    end
    if (p.col > DIM_BITS'(1)) begin
      r.col = p.col - DIM_BITS'(1);
    end else if (p.rows > DIM_BITS'(1)) begin
      r.rows = p.rows - DIM_BITS'(1);
      r.col  = w;
      if (c == tgarle_pkg::CORNER_BL) begin
        r.idx = r.idx - w2;
      end else if (c == tgarle_pkg::CORNER_TR) begin
        r.idx = r.idx + w2;
      end
    end else begin
      r.col  = '0;
      r.rows = '0;
      r.fin  = 1'b1;
    end
    return r;
  endfunction

  tgarle_pkg::state_e       state_q, state_d;
  logic [CNT_W-1:0]         left_q, left_d;
  logic [SLOT_W-1:0]        slot_q, slot_d;
  logic [PIX_W-1:0]         build_q, build_d;
  pos_t                     pos_q, pos_d;
  logic [2*DIM_BITS-1:0]    prod_q, prod_d;
  logic                     out_valid_q, out_valid_d;
  tgarle_pkg::res_t         out_q, out_d;

  logic                     out_free, in_item_state, do_item, is_begin, is_stream;
  logic                     is_hdr, is_pix, byte_last, pix_done, lit_emit, emit_go;
  logic                     take2, emit_last, load;
  logic [PB_W-1:0]          eff_bytes;
  logic [PIX_W-1:0]         new_build;
  logic [CNT_W-1:0]         emit_left;
  pos_t                     p1, p2;
  logic [IDX_W-1:0]         w32, prod32;

  assign out_free      = !out_valid_q || res_ready_i;
  assign in_item_state = (state_q == tgarle_pkg::ST_HEADER) || (state_q == tgarle_pkg::ST_LITERAL)
                         || (state_q == tgarle_pkg::ST_RUN);
  assign do_item       = item_valid_i && out_free && in_item_state;
  assign item_pop_o    = do_item;
  assign is_begin      = do_item && item_i.is_begin;
  assign is_stream     = do_item && !item_i.is_begin && !pos_q.fin;
  assign is_hdr        = is_stream && (state_q == tgarle_pkg::ST_HEADER);
  assign is_pix        = is_stream && (state_q != tgarle_pkg::ST_HEADER);

  always_comb begin
    if (pixel_bytes_i == '0) begin
      eff_bytes = PB_W'(1);
    end else if (pixel_bytes_i > PB_W'(MAX_PIXEL_BYTES)) begin
      eff_bytes = PB_W'(MAX_PIXEL_BYTES);
    end else begin
      eff_bytes = pixel_bytes_i;
    end
  end

  assign byte_last = (PB_W'(slot_q) + PB_W'(1)) >= eff_bytes;
  assign pix_done  = is_pix && byte_last;
  assign lit_emit  = pix_done && (state_q == tgarle_pkg::ST_LITERAL);
  assign emit_go   = (state_q == tgarle_pkg::ST_EMIT) && out_free;

  // byte lanes: slot zero starts a fresh pixel
  always_comb begin
    for (int k = 0; k < MAX_PIXEL_BYTES; k++) begin
      if (slot_q == SLOT_W'(k)) begin
        new_build[k*tgarle_pkg::BYTE_W +: tgarle_pkg::BYTE_W] = item_i.data;
      end else if (slot_q == '0) begin
        new_build[k*tgarle_pkg::BYTE_W +: tgarle_pkg::BYTE_W] = '0;
      end else begin
        new_build[k*tgarle_pkg::BYTE_W +: tgarle_pkg::BYTE_W] =
          build_q[k*tgarle_pkg::BYTE_W +: tgarle_pkg::BYTE_W];
      end
    end
  end

  assign p1        = step_pos(pos_q, width_i, corner_i);
  assign p2        = step_pos(p1, width_i, corner_i);
  assign take2     = (left_q > CNT_W'(1)) && !p1.fin;
  assign emit_left = left_q - (take2 ? CNT_W'(2) : CNT_W'(1));
  assign emit_last = (emit_left == '0) || (take2 ? p2.fin : p1.fin);
  assign load      = lit_emit || emit_go;
  assign w32       = IDX_W'(width_i);
  assign prod32    = IDX_W'(prod_q);

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      tgarle_pkg::ST_HEADER: begin
        if (is_begin) begin
          state_d = tgarle_pkg::ST_ORIGIN;
        end else if (is_hdr) begin
          state_d = item_i.is_run ? tgarle_pkg::ST_RUN : tgarle_pkg::ST_LITERAL;
        end
      end
      tgarle_pkg::ST_LITERAL: begin
        if (is_begin) begin
          state_d = tgarle_pkg::ST_ORIGIN;
        end else if (pix_done && left_q == CNT_W'(1)) begin
          state_d = tgarle_pkg::ST_HEADER;
        end
      end
      tgarle_pkg::ST_RUN: begin
        if (is_begin) begin
          state_d = tgarle_pkg::ST_ORIGIN;
        end else if (pix_done) begin
          state_d = tgarle_pkg::ST_EMIT;
        end
      end
      tgarle_pkg::ST_EMIT: begin
        if (emit_go && emit_last) begin
          state_d = tgarle_pkg::ST_HEADER;
        end
      end
      tgarle_pkg::ST_ORIGIN: begin
        state_d = tgarle_pkg::ST_HEADER;
      end
      default: begin
        state_d = tgarle_pkg::ST_HEADER;
      end
    endcase
  end

  // datapath and result
  always_comb begin
    left_d      = left_q;
    slot_d      = slot_q;
    build_d     = build_q;
    pos_d       = pos_q;
    prod_d      = prod_q;
    out_d       = out_q;
    out_valid_d = out_valid_q && !res_ready_i;

    if (is_begin) begin
      left_d  = '0;
      slot_d  = '0;
      build_d = '0;
      prod_d  = width_i * height_i;
    end else if (is_hdr) begin
      left_d  = item_i.count;
      slot_d  = '0;
      build_d = '0;
    end else if (is_pix) begin
      build_d = new_build;
      slot_d  = byte_last ? '0 : slot_q + SLOT_W'(1);
    end

    if (state_q == tgarle_pkg::ST_ORIGIN) begin
      pos_d.col  = width_i;
      pos_d.rows = height_i;
      pos_d.fin  = (width_i == '0) || (height_i == '0);
      if (pos_d.fin) begin
        pos_d.idx = '0;
      end else begin
        unique case (corner_i)
          tgarle_pkg::CORNER_BL: pos_d.idx = prod32 - w32;
          tgarle_pkg::CORNER_BR: pos_d.idx = prod32 - IDX_W'(1);
          tgarle_pkg::CORNER_TL: pos_d.idx = '0;
          tgarle_pkg::CORNER_TR: pos_d.idx = w32 - IDX_W'(1);
          default:               pos_d.idx = '0;
        endcase
      end
    end

    if (lit_emit) begin
      pos_d              = p1;
      left_d             = left_q - CNT_W'(1);
      out_d.first_index  = pos_q.idx;
      out_d.first_pixel  = tgarle_pkg::PIX_OUT_W'(new_build);
      out_d.second_valid = 1'b0;
      out_d.second_index = '0;
      out_d.second_pixel = '0;
      out_d.last_of_run  = 1'b1;
      out_d.image_done   = p1.fin;
    end else if (emit_go) begin
      pos_d              = take2 ? p2 : p1;
      left_d             = emit_last ? '0 : emit_left;
      out_d.first_index  = pos_q.idx;
      out_d.first_pixel  = tgarle_pkg::PIX_OUT_W'(build_q);
      out_d.second_valid = take2;
      out_d.second_index = take2 ? p1.idx : '0;
      out_d.second_pixel = take2 ? tgarle_pkg::PIX_OUT_W'(build_q) : '0;
      out_d.last_of_run  = emit_last;
      out_d.image_done   = take2 ? p2.fin : p1.fin;
    end

    if (load) begin
      out_valid_d = 1'b1;
    end
  end

  // reset leaves the position as a begin with a 1x1 top-left image
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= tgarle_pkg::ST_HEADER;
      left_q      <= '0;
      slot_q      <= '0;
      build_q     <= '0;
      pos_q.idx   <= '0;
      pos_q.col   <= DIM_BITS'(1);
      pos_q.rows  <= DIM_BITS'(1);
      pos_q.fin   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      left_q      <= left_d;
      slot_q      <= slot_d;
      build_q     <= build_d;
      pos_q       <= pos_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    prod_q <= prod_d;
    out_q  <= out_d;
  end

  assign res_valid_o = out_valid_q;
  assign res_o       = out_q;

  `TGARLE_ASSERT_IMPLY(a_emit_no_pop, state_q == tgarle_pkg::ST_EMIT, !item_pop_o, "item taken during run output")
  `TGARLE_ASSERT_NEXT(a_done_sets_fin, load && out_d.image_done, pos_q.fin, "image done without finish")
  `TGARLE_ASSERT_IMPLY(a_second_zero, out_valid_q && !out_q.second_valid, out_q.second_index == '0 && out_q.second_pixel == '0, "empty second slot not zero")

endmodule

`default_nettype wire

FILE: src/tga_rle_pixel_decoder_core.sv
// Decodes a TGA run-length pixel stream, one compressed byte per input word, into
// indexed pixel writes. A byte is taken each cycle while the two-word queue behind the
// input has room. A begin word passes through an origin state, as the origin index needs
// a registered width*height product. A literal pixel gives one result on its last byte;
// a run of n copies gives up to ceil(n/2) results, one per cycle while the output is
// ready, since the position unit steps twice per cycle and the input stalls meanwhile.
// Depends on tgarle_pkg, tgarle_front and tgarle_back.
`default_nettype none

module tga_rle_pixel_decoder_core #(
  parameter int unsigned MAX_PIXEL_BYTES = tgarle_pkg::MAX_PIXEL_BYTES_DEF,
  parameter int unsigned DIM_BITS        = tgarle_pkg::DIM_BITS_DEF
) (
  input  wire logic                                   clk_i,
  input  wire logic                                   rst_ni,
  input  wire logic                                   cfg_valid_i,
  output logic                                        cfg_ready_o,
  input  wire logic [tgarle_pkg::CFG_IDX_W-1:0]       cfg_index_i,
  input  wire logic [tgarle_pkg::CFG_DATA_W-1:0]      cfg_data_i,
  input  wire logic                                   s_axis_tvalid_i,
  output logic                                        s_axis_tready_o,
  input  wire logic [tgarle_pkg::BYTE_W-1:0]          s_axis_tdata_i,  // data_byte
  input  wire logic                                   s_axis_tuser_i,  // action
  output logic                                        m_axis_tvalid_o,
  input  wire logic                                   m_axis_tready_i,
  // first_index, first_pixel, second_index, second_pixel
  output logic [tgarle_pkg::TDATA_OUT_W-1:0]          m_axis_tdata_o,
  // second_valid, image_done
  output logic [tgarle_pkg::TUSER_OUT_W-1:0]          m_axis_tuser_o,
  output logic                                        m_axis_tlast_o   // last_of_run
);

  logic [tgarle_pkg::CFG_DIM_W-1:0] width_q, height_q;
  logic [tgarle_pkg::PB_W-1:0]      pixel_bytes_q;
  logic [tgarle_pkg::CORNER_W-1:0]  corner_q;
  logic                             cfg_we;

  tgarle_pkg::item_t                item;
  logic                             item_valid, item_pop;
  tgarle_pkg::res_t                 res;

  assign cfg_ready_o = 1'b1;
  assign cfg_we      = cfg_valid_i && cfg_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q       <= tgarle_pkg::RST_IMAGE_WIDTH;
      height_q      <= tgarle_pkg::RST_IMAGE_HEIGHT;
      pixel_bytes_q <= tgarle_pkg::RST_PIXEL_BYTES;
      corner_q      <= tgarle_pkg::RST_ORIGIN_CORNER;
    end else if (cfg_we) begin
      unique case (cfg_index_i)
        tgarle_pkg::CFG_IMAGE_WIDTH:   width_q       <= cfg_data_i;
        tgarle_pkg::CFG_IMAGE_HEIGHT:  height_q      <= cfg_data_i;
        tgarle_pkg::CFG_PIXEL_BYTES:   pixel_bytes_q <= cfg_data_i[tgarle_pkg::PB_W-1:0];
        tgarle_pkg::CFG_ORIGIN_CORNER: corner_q      <= cfg_data_i[tgarle_pkg::CORNER_W-1:0];
        default: ;
      endcase
    end
  end

  tgarle_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_valid_i    (s_axis_tvalid_i),
    .s_ready_o    (s_axis_tready_o),
    .action_i     (s_axis_tuser_i),
    .data_byte_i  (s_axis_tdata_i),
    .item_o       (item),
    .item_valid_o (item_valid),
    .item_pop_i   (item_pop)
  );

  tgarle_back #(
    .MAX_PIXEL_BYTES (MAX_PIXEL_BYTES),
    .DIM_BITS        (DIM_BITS)
  ) u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .item_i        (item),
    .item_valid_i  (item_valid),
    .item_pop_o    (item_pop),
    .width_i       (width_q[DIM_BITS-1:0]),
    .height_i      (height_q[DIM_BITS-1:0]),
    .pixel_bytes_i (pixel_bytes_q),
    .corner_i      (corner_q),
    .res_valid_o   (m_axis_tvalid_o),
    .res_ready_i   (m_axis_tready_i),
    .res_o         (res)
  );

  assign m_axis_tdata_o = {res.second_pixel, res.second_index, res.first_pixel, res.first_index};
  assign m_axis_tuser_o = {res.image_done, res.second_valid};
  assign m_axis_tlast_o = res.last_of_run;

endmodule

`default_nettype wire
